// ===== rtl/window_range_stability_detector_macros.svh =====
// Assertion macros for the window range stability detector.
`ifndef WINDOW_RANGE_STABILITY_DETECTOR_MACROS_SVH
`define WINDOW_RANGE_STABILITY_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define WRSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrsd: same-cycle check failed");
// Next-cycle implication.
`define WRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrsd: next-cycle check failed");
`else
`define WRSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wrsd_pkg.sv =====
// Shared constants and controller/datapath command types.
`default_nettype none
package wrsd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 8;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;

  localparam int unsigned        THRESH_WIDTH = 23;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(50);

  // request kind carried in tuser bit 0
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TARE   = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // take the input request this cycle
    logic tare;      // request is a tare
    logic rd_en;     // read one history entry at rd_addr
    logic rd_first;  // that read opens the min/max scan
    logic finish;    // load the result register
  } wrsd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result
  } wrsd_status_t;

endpackage
`default_nettype wire

// ===== rtl/wrsd_ctrl.sv =====
// Controller: sequences accept, history scan and result hand-off.
`default_nettype none
module wrsd_ctrl #(
  parameter int unsigned WINDOW_DEPTH = wrsd_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_tare_i,
  output logic                       in_ready_o,
  input  wire wrsd_pkg::wrsd_status_t status_i,
  output wrsd_pkg::wrsd_cmd_t        cmd_o,
  output logic [AW-1:0]              rd_addr_o
);
  import wrsd_pkg::*;
  `include "window_range_stability_detector_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e        state_q;
  logic [AW-1:0] cnt_q;
  logic          last_addr;

  assign last_addr = (cnt_q == AW'(WINDOW_DEPTH - 1));

  // decode commands from state
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = (state_q == S_IDLE);
    cmd_o.accept   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.tare     = cmd_o.accept && (in_tare_i == ACT_TARE);
    cmd_o.rd_en    = (state_q == S_SCAN);
    cmd_o.rd_first = (state_q == S_SCAN) && (cnt_q == '0);
    cmd_o.finish   = (state_q == S_DONE) && status_i.out_free;
  end

  assign rd_addr_o = cnt_q;

  // advance state and scan counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            state_q <= (in_tare_i == ACT_TARE) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (last_addr) begin
            cnt_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `WRSD_ASSERT_SAME(a_rd_in_range, clk_i, rst_ni, cmd_o.rd_en, rd_addr_o <= AW'(WINDOW_DEPTH - 1))
  `WRSD_ASSERT_SAME(a_no_accept_while_busy, clk_i, rst_ni, cmd_o.rd_en || cmd_o.finish, !in_ready_o)
  `WRSD_ASSERT_NEXT(a_scan_then_drain, clk_i, rst_ni, cmd_o.rd_en && last_addr, state_q == S_DRAIN)

endmodule
`default_nettype wire

// ===== rtl/wrsd_datapath.sv =====
// Datapath: weight register, history memory, min/max scan and result register.
`default_nettype none
module wrsd_datapath #(
  parameter int unsigned WINDOW_DEPTH = wrsd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = wrsd_pkg::SAMPLE_WIDTH_DEF,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH),
  localparam int unsigned WW = SAMPLE_WIDTH - 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire wrsd_pkg::wrsd_cmd_t               cmd_i,
  input  wire logic [AW-1:0]                     rd_addr_i,
  output wrsd_pkg::wrsd_status_t                 status_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  wire logic                              sample_ready_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [wrsd_pkg::THRESH_WIDTH-1:0] cfg_wdata_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [WW-1:0]                          out_weight_o,
  output logic                                   out_stable_o,
  output logic [WW-1:0]                          out_last_o
);
  import wrsd_pkg::*;
  `include "window_range_stability_detector_macros.svh"

  localparam int unsigned CW = (WW > THRESH_WIDTH) ? WW : THRESH_WIDTH;

  logic [THRESH_WIDTH-1:0] thresh_q;
  logic [WW-1:0]           cur_q, cur_d;
  logic [WW-1:0]           stable_q;
  logic                    tare_q;
  logic [AW-1:0]           wp_q;
  logic [WINDOW_DEPTH-1:0] valid_q;
  logic [WW-1:0]           mem [WINDOW_DEPTH];
  logic [WW-1:0]           rd_q;
  logic                    rdv_q, rd_en_q, rd_first_q;
  logic [WW-1:0]           entry;
  logic [WW-1:0]           lo_q, hi_q;
  logic [CW-1:0]           range_ext, thresh_ext;
  logic                    st;
  logic                    out_valid_q, out_stable_q;
  logic [WW-1:0]           out_weight_q, out_last_q;

  // clamp negatives to zero, hold weight when the sensor had nothing fresh
  always_comb begin
    if (!sample_ready_i) begin
      cur_d = cur_q;
    end else if (sample_i[SAMPLE_WIDTH-1]) begin
      cur_d = '0;
    end else begin
      cur_d = sample_i[WW-1:0];
    end
  end

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // weight, last stable weight, write pointer and entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      stable_q <= '0;
      tare_q   <= 1'b0;
      wp_q     <= '0;
      valid_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        tare_q <= cmd_i.tare;
        if (cmd_i.tare) begin
          cur_q    <= '0;
          stable_q <= '0;
          valid_q  <= '0;
        end else begin
          cur_q         <= cur_d;
          valid_q[wp_q] <= 1'b1;
          wp_q          <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        end
      end
      if (cmd_i.finish && st) begin
        stable_q <= cur_q;
      end
    end
  end

  // history memory: write on a sample request, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !cmd_i.tare) begin
      mem[wp_q] <= cur_d;
    end
    rd_q <= mem[rd_addr_i];
  end

  // read tags; an entry never written since reset or tare reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q      <= 1'b0;
      rd_en_q    <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rdv_q      <= valid_q[rd_addr_i];
      rd_en_q    <= cmd_i.rd_en;
      rd_first_q <= cmd_i.rd_first;
    end
  end

  assign entry = rdv_q ? rd_q : '0;

  // running min and max over the window, one entry a cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_q) begin
      if (rd_first_q || entry < lo_q) begin
        lo_q <= entry;
      end
      if (rd_first_q || entry > hi_q) begin
        hi_q <= entry;
      end
    end
  end

  // window range against threshold
  assign range_ext  = CW'(hi_q - lo_q);
  assign thresh_ext = CW'(thresh_q);
  assign st         = !tare_q && (range_ext < thresh_ext);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_weight_q <= cur_q;
      out_stable_q <= st;
      out_last_q   <= st ? cur_q : stable_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_weight_o      = out_weight_q;
  assign out_stable_o      = out_stable_q;
  assign out_last_o        = out_last_q;

  `WRSD_ASSERT_NEXT(a_tare_clears, clk_i, rst_ni, cmd_i.tare, cur_q == '0 && stable_q == '0 && valid_q == '0)
  `WRSD_ASSERT_SAME(a_finish_has_room, clk_i, rst_ni, cmd_i.finish, !out_valid_q || out_ready_i)
  `WRSD_ASSERT_SAME(a_scan_ordered, clk_i, rst_ni, rd_en_q && !rd_first_q, lo_q <= hi_q)

endmodule
`default_nettype wire

// ===== rtl/window_range_stability_detector.sv =====
// Top level: load-cell window range stability detector.
//
//  Port group        Dir  Handshake               Contents
//  s_axis_*          in   tvalid/tready           sample request (tdata, tuser)
//  m_axis_*          out  tvalid/tready           result (tdata, tuser)
//  cfg_*             in   cfg_we_i, no wait       stability threshold, 23 bits
//
//  A sample request writes the history on accept, then scans it through the single
//  read port, waits for the last read and loads the result; a tare request goes
//  straight to loading the result. rst_ni (asynchronous, active low) clears the
//  history valid bits, weights and pointer at once; the threshold returns to 50.
//  A new request is taken while a result waits; the block holds in its last step
//  until m_axis_tready frees it.
`default_nettype none
module window_range_stability_detector #(
  parameter int unsigned WINDOW_DEPTH = wrsd_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = wrsd_pkg::SAMPLE_WIDTH_DEF,
  localparam int unsigned WW = SAMPLE_WIDTH - 1,
  localparam int unsigned IN_DW = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW = ((2 * WW + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [IN_DW-1:0]                  s_axis_tdata,  // sample
  input  wire logic [1:0]                        s_axis_tuser,  // action, sample_ready
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [OUT_DW-1:0]                      m_axis_tdata,  // weight, last_stable
  output logic                                   m_axis_tuser,  // stable
  input  wire logic                              cfg_we_i,
  input  wire logic [wrsd_pkg::THRESH_WIDTH-1:0] cfg_wdata_i
);
  import wrsd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  wrsd_cmd_t    cmd;
  wrsd_status_t status;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] out_weight, out_last;
  logic          out_stable;

  wrsd_ctrl #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_tare_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  wrsd_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .status_o       (status),
    .sample_i       (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .sample_ready_i (s_axis_tuser[1]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_weight_o   (out_weight),
    .out_stable_o   (out_stable),
    .out_last_o     (out_last)
  );

  // pack result fields, weight in the low bits
  assign m_axis_tdata = OUT_DW'({out_last, out_weight});
  assign m_axis_tuser = out_stable;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the window range stability detector.
module testbench;
  import wrsd_pkg::*;

  localparam int unsigned DEPTH     = WINDOW_DEPTH_DEF;
  localparam int unsigned SW        = SAMPLE_WIDTH_DEF;
  localparam int unsigned WW        = SW - 1;
  localparam int unsigned IN_DW     = ((SW + 7) / 8) * 8;
  localparam int unsigned OUT_DW    = ((2 * WW + 7) / 8) * 8;
  localparam int unsigned MAX_W     = (1 << WW) - 1;
  localparam int unsigned QUIET_MAX = 5000;

  typedef struct packed {
    logic                 action;
    logic signed [SW-1:0] sample;
    logic                 fresh;
  } reading_t;

  typedef struct packed {
    logic [WW-1:0] weight;
    logic          stable;
    logic [WW-1:0] last_stable;
  } weighing_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DW-1:0]        s_tdata  = '0;  // sample
  logic [1:0]              s_tuser  = '0;  // action, sample_ready
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DW-1:0]       m_tdata;        // weight, last_stable
  logic                    m_tuser;        // stable
  logic                    cfg_we    = 1'b0;
  logic [THRESH_WIDTH-1:0] cfg_wdata = '0;

  // Predictor state
  logic [SW-1:0]           win_hist [DEPTH];
  int unsigned             win_ptr = 0;
  logic [WW-1:0]           cur_weight = '0;
  logic [WW-1:0]           held_stable = '0;
  logic [THRESH_WIDTH-1:0] thr_model = THRESH_RESET;

  reading_t    readings_pending [$];
  weighing_t   weighings_expected [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  window_range_stability_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < DEPTH; i++) win_hist[i] = '0;
  end

  // Compute the expected answer to one accepted request
  task automatic predict_weighing(input logic act, input logic [SW-1:0] smp,
                                  input logic fresh);
    weighing_t     res;
    logic [WW-1:0] w;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    if (act == ACT_TARE) begin
      for (int i = 0; i < DEPTH; i++) win_hist[i] = '0;
      cur_weight  = '0;
      held_stable = '0;
      res = '0;
    end else begin
      if (fresh) w = smp[SW-1] ? '0 : smp[WW-1:0];
      else w = cur_weight;
      cur_weight = w;
      win_hist[win_ptr] = {1'b0, w};
      win_ptr = (win_ptr + 1) % DEPTH;
      lo = win_hist[0];
      hi = win_hist[0];
      for (int i = 1; i < DEPTH; i++) begin
        if (win_hist[i] < lo) lo = win_hist[i];
        if (win_hist[i] > hi) hi = win_hist[i];
      end
      res.stable = ((hi - lo) < {1'b0, thr_model});
      if (res.stable) held_stable = w;
      res.weight      = w;
      res.last_stable = held_stable;
    end
    weighings_expected.push_back(res);
  endtask

  // Drive requests from the pending queue, predict each one as it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) predict_weighing(s_tuser[0], s_tdata[SW-1:0], s_tuser[1]);
      if (!s_tvalid || s_tready) begin
        if (readings_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          reading_t r;
          r = readings_pending.pop_front();
          s_tdata  <= IN_DW'(r.sample);
          s_tuser  <= {r.fresh, r.action};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        weighing_t want;
        weighing_t got;
        got.weight      = m_tdata[WW-1:0];
        got.last_stable = m_tdata[2*WW-1:WW];
        got.stable      = m_tuser;
        if (weighings_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: weight=%0d stable=%0d last_stable=%0d",
                     got.weight, got.stable, got.last_stable);
        end else begin
          want = weighings_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected weight=%0d stable=%0d last_stable=%0d, %s%0d %0d %0d",
                       want.weight, want.stable, want.last_stable,
                       "got ", got.weight, got.stable, got.last_stable);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_reading(input logic act, input int smp, input logic fresh);
    reading_t r;
    r.action = act;
    r.sample = SW'(smp);
    r.fresh  = fresh;
    readings_pending.push_back(r);
  endtask

  // Hold until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (readings_pending.size() != 0 || s_tvalid || weighings_expected.size() != 0);
  endtask

  task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    thr_model = value;
  endtask

  // Runs of nearby weights so the window settles, mixed with tares, stale
  // readings, negative readings and noise
  task automatic queue_random_readings(input int unsigned count);
    int unsigned n;
    int unsigned base;
    int unsigned span;
    int unsigned run_len;
    int unsigned roll;
    int unsigned v;
    reading_t    r;
    n = 0;
    while (n < count) begin
      case ($urandom_range(3))
        0: base = $urandom_range(0, 200);
        1: base = $urandom_range(0, MAX_W);
        2: base = $urandom_range(MAX_W - 2000, MAX_W);
        default: base = $urandom_range(0, 100000);
      endcase
      case ($urandom_range(3))
        0: span = 0;
        1: span = thr_model / 2;
        2: span = thr_model;
        default: span = 2 * thr_model + 1;
      endcase
      if (span > MAX_W) span = MAX_W;
      run_len = $urandom_range(6, 24);
      for (int k = 0; k < run_len && n < count; k++) begin
        roll     = $urandom_range(99);
        r.action = ACT_SAMPLE;
        r.fresh  = 1'b1;
        r.sample = SW'($urandom);
        if (roll < 3) r.action = ACT_TARE;
        else if (roll < 12) r.fresh = 1'b0;
        else if (roll < 16) r.sample[SW-1] = 1'b1;
        else if (roll >= 20) begin
          v = base + $urandom_range(0, span);
          if (v > MAX_W) v = MAX_W;
          r.sample = SW'(v);
        end
        readings_pending.push_back(r);
        n++;
      end
    end
  endtask

  initial begin
    logic [THRESH_WIDTH-1:0] thr_list [6];
    send_idle_pct = 30;
    recv_idle_pct = 67;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, clamp, stale reading, tare, threshold edge at reset value
    add_reading(ACT_SAMPLE, 0, 1'b1);
    add_reading(ACT_SAMPLE, MAX_W, 1'b1);
    add_reading(ACT_SAMPLE, -8388608, 1'b1);
    add_reading(ACT_SAMPLE, -1, 1'b1);
    add_reading(ACT_SAMPLE, 12345, 1'b1);
    add_reading(ACT_SAMPLE, -1, 1'b0);
    add_reading(ACT_TARE, -1, 1'b1);
    for (int i = 0; i < 7; i++) add_reading(ACT_SAMPLE, 1000, 1'b1);
    add_reading(ACT_SAMPLE, 1049, 1'b1);
    add_reading(ACT_SAMPLE, 1050, 1'b1);
    add_reading(ACT_SAMPLE, 0, 1'b0);
    add_reading(ACT_TARE, 0, 1'b0);
    wait_drained();

    // Directed: window range against the widest threshold
    write_threshold(THRESH_WIDTH'(MAX_W));
    add_reading(ACT_TARE, 0, 1'b1);
    add_reading(ACT_SAMPLE, MAX_W, 1'b1);
    add_reading(ACT_TARE, 0, 1'b1);
    add_reading(ACT_SAMPLE, MAX_W - 1, 1'b1);
    wait_drained();

    // Random phases over several thresholds and idle patterns
    thr_list[0] = '0;
    thr_list[1] = THRESH_WIDTH'(MAX_W);
    thr_list[2] = THRESH_WIDTH'(50);
    thr_list[3] = THRESH_WIDTH'($urandom_range(1, 2000));
    thr_list[4] = THRESH_WIDTH'($urandom_range(0, MAX_W));
    thr_list[5] = THRESH_WIDTH'(1);
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_threshold(thr_list[p]);
      queue_random_readings(330);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && weighings_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
